// ----- hdl/fci_pkg.sv -----
// ----------------------------------------------------------------------------
// Fan curve interpolator package
// Shared widths, register indexes, reset values and point field helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package fci_pkg;

   // Field widths.
   localparam int TEMP_W  = 16;   // signed temperature, tenths of a degree
   localparam int RPM_W   = 15;   // fan speed in rpm
   localparam int POINT_W = 31;   // packed curve point: rpm in 30:16, temperature in 15:0
   localparam int COUNT_W = 3;    // point count register
   localparam int SPAN_W  = 16;   // temperature span and offset between two points
   localparam int PROD_W  = 31;   // speed span times temperature offset
   localparam int QUOT_W  = 15;   // quotient never exceeds the speed span

   // Register indexes on the configuration port.
   localparam int REG_POINT_COUNT = 0;
   localparam int REG_POINT_BASE  = 1;

   // Values after reset.
   localparam logic [COUNT_W-1:0] DEFAULT_POINT_COUNT = 3'd4;
   localparam int DEFAULT_POINTS_N = 4;
   localparam logic [POINT_W-1:0] DEFAULT_POINTS [DEFAULT_POINTS_N] = '{
      31'd157286750,   // 35.0 C,  2400 rpm
      31'd327680550,   // 55.0 C,  5000 rpm
      31'd589824700,   // 70.0 C,  9000 rpm
      31'd819200820    // 82.0 C, 12500 rpm
   };

   // Data that rides along the divider next to the dividend.
   typedef struct packed {
      logic [RPM_W-1:0] rpm_base;   // speed the quotient is added to or taken from
      logic             negative;   // speed falls across the span
   } fci_side_type;

   function automatic logic signed [TEMP_W-1:0] pt_temp(input logic [POINT_W-1:0] p);
      return signed'(p[TEMP_W-1:0]);
   endfunction

   function automatic logic [RPM_W-1:0] pt_rpm(input logic [POINT_W-1:0] p);
      return p[POINT_W-1:TEMP_W];
   endfunction

endpackage

`default_nettype wire

// ----- hdl/fan_curve_interpolator.sv -----
// A request passes through the stage 1 to 3 registers, the 15 divider stages and the
// response register, which holds its response until it is taken.
// Throughput: one temperature per cycle unless stalled; the divider is fully pipelined.
// A stalled response holds the whole pipeline; nothing is dropped or repeated.
// Reset (synchronous, active high) empties the pipeline and restores the default curve.
// ----------------------------------------------------------------------------
// Fan curve interpolator
// Maps a signed temperature onto a piecewise linear fan curve of up to
// CURVE_POINTS configured points and returns the target fan speed in rpm.
// ----------------------------------------------------------------------------
`default_nettype none

module fan_curve_interpolator #(
   parameter  int CURVE_POINTS = 4,
   localparam int CSR_IDX_W    = $clog2(CURVE_POINTS + 1)
) (
   input  logic                              clock,
   input  logic                              reset,

   // Request channel: one temperature per transfer.
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [fci_pkg::TEMP_W-1:0] req_temperature,

   // Response channel: one target speed per request.
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [fci_pkg::RPM_W-1:0]         rsp_target_speed,

   // Register write channel. Index 0 is the point count, index 1 + i is point i.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [CSR_IDX_W-1:0]              csr_index,
   input  logic [fci_pkg::POINT_W-1:0]       csr_data
);
   import fci_pkg::*;

   localparam int PIDX_W = (CURVE_POINTS > 1) ? $clog2(CURVE_POINTS) : 1;

   // ------------------------------------------------------------------------
   // Configuration registers, writes always taken. Software must write them
   // only with the pipeline empty (not enforced); every stage reads them directly.
   // ------------------------------------------------------------------------
   logic [COUNT_W-1:0] point_count_ff;
   logic [POINT_W-1:0] point_ff [CURVE_POINTS];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= DEFAULT_POINT_COUNT;
      end else if (csr_valid && csr_index == CSR_IDX_W'(REG_POINT_COUNT)) begin
         point_count_ff <= csr_data[COUNT_W-1:0];
      end
   end

   genvar p;
   for (p = 0; p < CURVE_POINTS; p++) begin : g_point
      always_ff @(posedge clock) begin
         if (reset) begin
            if (p < DEFAULT_POINTS_N) begin
               point_ff[p] <= DEFAULT_POINTS[p % DEFAULT_POINTS_N];
            end else begin
               point_ff[p] <= '0;
            end
         end else if (csr_valid && csr_index == CSR_IDX_W'(REG_POINT_BASE + p)) begin
            point_ff[p] <= csr_data;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Flow control. The response register is the last stage; every stage moves
   // together whenever that register is empty or its content is being taken.
   // ------------------------------------------------------------------------
   logic advance;

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // ------------------------------------------------------------------------
   // Stage 1: compare the temperature against every point and pick the
   // segment. A count of zero acts as one point and counts above the
   // number of points saturate. The chosen index is the point whose speed is
   // returned as-is when clamping, or the upper point of the segment otherwise.
   // ------------------------------------------------------------------------
   logic [COUNT_W-1:0]         used_count;
   logic [PIDX_W-1:0]          last_idx;
   logic [CURVE_POINTS-1:0]    at_or_below;
   logic                       at_or_above_last;
   logic [PIDX_W-1:0]          upper_idx;
   logic                       found;
   logic                       s1_clamp_in;
   logic [PIDX_W-1:0]          s1_idx_in;

   always_comb begin
      if (point_count_ff == '0) begin
         used_count = COUNT_W'(1);
      end else if (point_count_ff > COUNT_W'(CURVE_POINTS)) begin
         used_count = COUNT_W'(CURVE_POINTS);
      end else begin
         used_count = point_count_ff;
      end
      last_idx = PIDX_W'(used_count - COUNT_W'(1));
   end

   always_comb begin
      at_or_above_last = 1'b0;
      for (int j = 0; j < CURVE_POINTS; j++) begin
         at_or_below[j] = req_temperature <= pt_temp(point_ff[j]);
         if (PIDX_W'(j) == last_idx) begin
            at_or_above_last = req_temperature >= pt_temp(point_ff[j]);
         end
      end
   end

   // First point in use, above the first one, that is not below the temperature.
   always_comb begin
      found     = 1'b0;
      upper_idx = last_idx;
      for (int j = 1; j < CURVE_POINTS; j++) begin
         if (!found && PIDX_W'(j) <= last_idx && at_or_below[j]) begin
            found     = 1'b1;
            upper_idx = PIDX_W'(j);
         end
      end
   end

   always_comb begin
      if (at_or_below[0]) begin
         s1_clamp_in = 1'b1;
         s1_idx_in   = '0;
      end else if (at_or_above_last) begin
         s1_clamp_in = 1'b1;
         s1_idx_in   = last_idx;
      end else begin
         s1_clamp_in = 1'b0;
         s1_idx_in   = upper_idx;
      end
   end

   logic                      s1_valid_ff;
   logic signed [TEMP_W-1:0]  s1_temp_ff;
   logic                      s1_clamp_ff;
   logic [PIDX_W-1:0]         s1_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_temp_ff  <= req_temperature;
         s1_clamp_ff <= s1_clamp_in;
         s1_idx_ff   <= s1_idx_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: fetch the segment end points and form the spans. The selected
   // segment always has its lower temperature below the input and its upper
   // temperature at or above it, so the offset never exceeds the span and
   // the span is never zero. A clamped item goes through as 0 / 1.
   // ------------------------------------------------------------------------
   logic signed [TEMP_W-1:0]  up_temp;
   logic signed [TEMP_W-1:0]  lo_temp;
   logic [RPM_W-1:0]          up_rpm;
   logic [RPM_W-1:0]          lo_rpm;
   logic signed [TEMP_W:0]    off_wide;
   logic signed [TEMP_W:0]    span_wide;
   logic [RPM_W:0]            rpm_diff;
   logic [SPAN_W-1:0]         s2_off_in;
   logic [SPAN_W-1:0]         s2_span_in;
   logic [RPM_W-1:0]          s2_mag_in;
   fci_side_type              s2_side_in;

   always_comb begin
      up_temp = '0;
      up_rpm  = '0;
      lo_temp = '0;
      lo_rpm  = '0;
      for (int j = 0; j < CURVE_POINTS; j++) begin
         if (s1_idx_ff == PIDX_W'(j)) begin
            up_temp = pt_temp(point_ff[j]);
            up_rpm  = pt_rpm(point_ff[j]);
         end
      end
      for (int j = 0; j < CURVE_POINTS - 1; j++) begin
         if (s1_idx_ff == PIDX_W'(j + 1)) begin
            lo_temp = pt_temp(point_ff[j]);
            lo_rpm  = pt_rpm(point_ff[j]);
         end
      end
   end

   always_comb begin
      off_wide  = (TEMP_W + 1)'(s1_temp_ff) - (TEMP_W + 1)'(lo_temp);
      span_wide = (TEMP_W + 1)'(up_temp) - (TEMP_W + 1)'(lo_temp);
      rpm_diff  = {1'b0, up_rpm} - {1'b0, lo_rpm};
      if (s1_clamp_ff) begin
         s2_off_in           = '0;
         s2_span_in          = SPAN_W'(1);
         s2_mag_in           = '0;
         s2_side_in.rpm_base = up_rpm;
         s2_side_in.negative = 1'b0;
      end else begin
         s2_off_in           = off_wide[SPAN_W-1:0];
         s2_span_in          = span_wide[SPAN_W-1:0];
         s2_side_in.rpm_base = lo_rpm;
         s2_side_in.negative = rpm_diff[RPM_W];
         if (rpm_diff[RPM_W]) begin
            s2_mag_in = RPM_W'(-rpm_diff);
         end else begin
            s2_mag_in = rpm_diff[RPM_W-1:0];
         end
      end
   end

   logic                s2_valid_ff;
   logic [SPAN_W-1:0]   s2_off_ff;
   logic [SPAN_W-1:0]   s2_span_ff;
   logic [RPM_W-1:0]    s2_mag_ff;
   fci_side_type        s2_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s2_off_ff  <= s2_off_in;
         s2_span_ff <= s2_span_in;
         s2_mag_ff  <= s2_mag_in;
         s2_side_ff <= s2_side_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: speed span magnitude times temperature offset (15 x 16 bits).
   // ------------------------------------------------------------------------
   logic                s3_valid_ff;
   logic [PROD_W-1:0]   s3_prod_ff;
   logic [SPAN_W-1:0]   s3_span_ff;
   fci_side_type        s3_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_prod_ff <= PROD_W'(s2_mag_ff) * PROD_W'(s2_off_ff);
         s3_span_ff <= s2_span_ff;
         s3_side_ff <= s2_side_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stages 4 to 18: truncating division by the temperature span. Both
   // operands are non-negative, so the floor equals truncation toward zero.
   // ------------------------------------------------------------------------
   logic                div_valid;
   logic [QUOT_W-1:0]   div_quotient;
   fci_side_type        div_side;

   fci_divider u_divider (
      .clock        (clock),
      .reset        (reset),
      .enable       (advance),
      .in_valid     (s3_valid_ff),
      .in_dividend  (s3_prod_ff),
      .in_divisor   (s3_span_ff),
      .in_side      (s3_side_ff),
      .out_valid    (div_valid),
      .out_quotient (div_quotient),
      .out_side     (div_side)
   );

   // ------------------------------------------------------------------------
   // Stage 19: apply the signed quotient to the lower speed and hold the
   // result in the response register. The quotient never exceeds the speed
   // span, so the result always lies between the two point speeds.
   // ------------------------------------------------------------------------
   logic                rsp_valid_ff;
   logic [RPM_W-1:0]    rsp_speed_ff;
   logic [RPM_W-1:0]    rsp_speed_in;

   always_comb begin
      if (div_side.negative) begin
         rsp_speed_in = div_side.rpm_base - div_quotient;
      end else begin
         rsp_speed_in = div_side.rpm_base + div_quotient;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_speed_ff <= rsp_speed_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_target_speed = rsp_speed_ff;

endmodule

`default_nettype wire

// ----- hdl/fci_divider.sv -----
// ----------------------------------------------------------------------------
// Fan curve interpolator divider
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module fci_divider (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         enable,
   input  logic                         in_valid,
   input  logic [fci_pkg::PROD_W-1:0]   in_dividend,
   input  logic [fci_pkg::SPAN_W-1:0]   in_divisor,
   input  fci_pkg::fci_side_type        in_side,
   output logic                         out_valid,
   output logic [fci_pkg::QUOT_W-1:0]   out_quotient,
   output fci_pkg::fci_side_type        out_side
);
   import fci_pkg::*;

   // The dividend is always below divisor times 2**QUOT_W, so QUOT_W steps suffice.
   logic                valid_ff [QUOT_W];
   logic [PROD_W-1:0]   rem_ff   [QUOT_W];
   logic [SPAN_W-1:0]   div_ff   [QUOT_W];
   logic [QUOT_W-1:0]   quot_ff  [QUOT_W];
   fci_side_type        side_ff  [QUOT_W];

   genvar s;
   for (s = 0; s < QUOT_W; s++) begin : g_stage
      localparam int BIT = QUOT_W - 1 - s;

      logic                valid_cur;
      logic [PROD_W-1:0]   rem_cur;
      logic [SPAN_W-1:0]   div_cur;
      logic [QUOT_W-1:0]   quot_cur;
      fci_side_type        side_cur;
      logic [PROD_W-1:0]   trial;
      logic [PROD_W-1:0]   rem_in;
      logic [QUOT_W-1:0]   quot_in;

      if (s == 0) begin : g_first
         assign valid_cur = in_valid;
         assign rem_cur   = in_dividend;
         assign div_cur   = in_divisor;
         assign quot_cur  = '0;
         assign side_cur  = in_side;
      end else begin : g_next
         assign valid_cur = valid_ff[s-1];
         assign rem_cur   = rem_ff[s-1];
         assign div_cur   = div_ff[s-1];
         assign quot_cur  = quot_ff[s-1];
         assign side_cur  = side_ff[s-1];
      end

      assign trial = PROD_W'(div_cur) << BIT;

      always_comb begin
         if (rem_cur >= trial) begin
            rem_in  = rem_cur - trial;
            quot_in = quot_cur | (QUOT_W'(1) << BIT);
         end else begin
            rem_in  = rem_cur;
            quot_in = quot_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (enable) begin
            valid_ff[s] <= valid_cur;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[s]  <= rem_in;
            div_ff[s]  <= div_cur;
            quot_ff[s] <= quot_in;
            side_ff[s] <= side_cur;
         end
      end
   end

   assign out_valid    = valid_ff[QUOT_W-1];
   assign out_quotient = quot_ff[QUOT_W-1];
   assign out_side     = side_ff[QUOT_W-1];

endmodule

`default_nettype wire
